[sv/aphr_pkg.sv]
// Package for the user-agent peak ratio block.
// Holds the transaction payload types, table entry type, state enum and a shared saturating-increment helper.
// No dependencies.
`timescale 1ns / 1ps

package aphr_pkg;

    localparam int RATIO_FRAC_BITS = 16;
    localparam logic [16:0] RATIO_ONE = 17'h10000;

    localparam logic [1:0] KIND_EXISTING = 2'd0;
    localparam logic [1:0] KIND_NEW      = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [31:0] agent_hash;
        logic [31:0] total_requests;
    } in_t;

    typedef struct packed {
        logic [16:0] peak_ratio;
        logic [31:0] peak_requests;
        logic [1:0]  hit_kind;
        logic [31:0] overflow_requests;
        logic        zero_total;
    } out_t;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] count;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_ALLOC,
        ST_PEAK,
        ST_DIV_START,
        ST_DIV_WAIT
    } state_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

[sv/aphr_table.sv]
// Tracked-hash table: one write port and one registered read port.
// Depends on aphr_pkg for the entry type.
`timescale 1ns / 1ps

module aphr_table #(
    parameter int DEPTH = 15,
    parameter int AW    = 4
) (
    input  logic               clk,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output aphr_pkg::entry_t   rd_data,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  aphr_pkg::entry_t   wr_data
);

    aphr_pkg::entry_t mem [DEPTH];
    aphr_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/aphr_div.sv]
// Serial restoring divider producing a saturated Q1.16 ratio, one quotient bit per cycle.
// Depends on aphr_pkg for the ratio constants.
`timescale 1ns / 1ps

module aphr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [16:0] quotient
);

    localparam int SW = $clog2(aphr_pkg::RATIO_FRAC_BITS);
    localparam logic [SW-1:0] LAST_STEP = SW'(aphr_pkg::RATIO_FRAC_BITS - 1);

    logic          busy_reg, busy_next;
    logic [SW-1:0] step_reg, step_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   div_reg, div_next;
    logic [16:0]   quo_reg, quo_next;
    logic [32:0]   rem_sh;
    logic [32:0]   rem_diff;
    logic          fits;

    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign fits     = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            div_next  = divisor;
            rem_next  = dividend;
            step_next = '0;
            if (divisor == 32'd0)
            begin
                quo_next  = '0;
                busy_next = 1'b0;
            end
            else if (dividend >= divisor)
            begin
                quo_next  = aphr_pkg::RATIO_ONE;
                busy_next = 1'b0;
            end
            else
            begin
                quo_next  = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_diff[31:0] : rem_sh[31:0];
            quo_next  = {quo_reg[15:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[sv/agent_hash_peak_ratio.sv]
// Top level of the user-agent peak ratio block: sequencer, counters and output register.
// Depends on aphr_pkg, aphr_table and aphr_div.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------
//  input   | in_valid / in_ready | in_data  (aphr_pkg::in_t)
//  output  | out_valid/out_ready | out_data (aphr_pkg::out_t)
//
// A transaction reads k table entries (at most TABLE_SLOTS-1) and allocates a new entry when
// the hash is not found and the table is not full: the single table read port walks one entry
// per pair of read and compare states, and the serial divider takes 16 steps.
// A zero total or a ratio at one skips the divider steps.
// Reset clears the counters and the fill count; the table contents need no clearing.
// in_ready is high only while idle; a finished result waits in the output register and
// does not block the next input transaction, but a further result waits for it.
`timescale 1ns / 1ps

module agent_hash_peak_ratio #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  aphr_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output aphr_pkg::out_t  out_data
);

    localparam int TRACKED = TABLE_SLOTS - 1;
    localparam int AW = $clog2(TABLE_SLOTS);
    localparam logic [AW-1:0] FULL_COUNT = AW'(TRACKED);

    aphr_pkg::state_t state_reg, state_next;

    logic [31:0]    hash_reg, hash_next;
    logic [31:0]    total_reg, total_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]  used_reg, used_next;
    logic [31:0]    ovf_reg, ovf_next;
    logic [31:0]    peak_reg, peak_next;
    logic [31:0]    cur_reg, cur_next;
    logic [1:0]     kind_reg, kind_next;
    logic           out_valid_reg, out_valid_next;
    aphr_pkg::out_t out_data_reg, out_data_next;

    aphr_pkg::entry_t tbl_rd;
    aphr_pkg::entry_t tbl_wr;
    logic [AW-1:0]    tbl_wr_addr;
    logic             tbl_rd_en;
    logic             tbl_wr_en;
    logic             div_start;
    logic             div_busy;
    logic [16:0]      div_quo;
    logic             hit;
    logic             last;
    logic             full;
    logic             out_load;

    assign hit  = tbl_rd.hash == hash_reg;
    assign last = AW'(idx_reg + 1'b1) == used_reg;
    assign full = used_reg == FULL_COUNT;

    aphr_table #(
        .DEPTH (TRACKED),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .rd_en   (tbl_rd_en),
        .rd_addr (idx_reg),
        .rd_data (tbl_rd),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr)
    );

    aphr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (peak_reg),
        .divisor  (total_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aphr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (used_reg == '0) ? aphr_pkg::ST_ALLOC : aphr_pkg::ST_READ;
                end
            end
            aphr_pkg::ST_READ:
            begin
                state_next = aphr_pkg::ST_COMPARE;
            end
            aphr_pkg::ST_COMPARE:
            begin
                priority if (hit)
                begin
                    state_next = aphr_pkg::ST_PEAK;
                end
                else if (last)
                begin
                    state_next = full ? aphr_pkg::ST_PEAK : aphr_pkg::ST_ALLOC;
                end
                else
                begin
                    state_next = aphr_pkg::ST_READ;
                end
            end
            aphr_pkg::ST_ALLOC:
            begin
                state_next = aphr_pkg::ST_PEAK;
            end
            aphr_pkg::ST_PEAK:
            begin
                state_next = aphr_pkg::ST_DIV_START;
            end
            aphr_pkg::ST_DIV_START:
            begin
                state_next = aphr_pkg::ST_DIV_WAIT;
            end
            aphr_pkg::ST_DIV_WAIT:
            begin
                if (!div_busy && (!out_valid_reg || out_ready))
                begin
                    state_next = aphr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aphr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = state_reg == aphr_pkg::ST_IDLE;
        tbl_rd_en   = state_reg == aphr_pkg::ST_READ;
        div_start   = state_reg == aphr_pkg::ST_DIV_START;
        tbl_wr_en   = (state_reg == aphr_pkg::ST_ALLOC) ||
                      ((state_reg == aphr_pkg::ST_COMPARE) && hit);
        tbl_wr_addr = (state_reg == aphr_pkg::ST_ALLOC) ? used_reg : idx_reg;
        tbl_wr.hash = hash_reg;
        tbl_wr.count = (state_reg == aphr_pkg::ST_ALLOC) ? 32'd1
                                                         : aphr_pkg::sat_inc(tbl_rd.count);
        out_load    = (state_reg == aphr_pkg::ST_DIV_WAIT) && !div_busy &&
                      (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        hash_next      = hash_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        ovf_next       = ovf_reg;
        peak_next      = peak_reg;
        cur_next       = cur_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            aphr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    hash_next  = in_data.agent_hash;
                    total_next = in_data.total_requests;
                    idx_next   = '0;
                end
            end
            aphr_pkg::ST_COMPARE:
            begin
                priority if (hit)
                begin
                    cur_next  = aphr_pkg::sat_inc(tbl_rd.count);
                    kind_next = aphr_pkg::KIND_EXISTING;
                end
                else if (last)
                begin
                    if (full)
                    begin
                        ovf_next  = aphr_pkg::sat_inc(ovf_reg);
                        cur_next  = '0;
                        kind_next = aphr_pkg::KIND_OVERFLOW;
                    end
                end
                else
                begin
                    idx_next = AW'(idx_reg + 1'b1);
                end
            end
            aphr_pkg::ST_ALLOC:
            begin
                used_next = AW'(used_reg + 1'b1);
                cur_next  = 32'd1;
                kind_next = aphr_pkg::KIND_NEW;
            end
            aphr_pkg::ST_PEAK:
            begin
                if (cur_reg > peak_reg)
                begin
                    peak_next = cur_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next                  = 1'b1;
            out_data_next.peak_ratio        = div_quo;
            out_data_next.peak_requests     = peak_reg;
            out_data_next.hit_kind          = kind_reg;
            out_data_next.overflow_requests = ovf_reg;
            out_data_next.zero_total        = total_reg == 32'd0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aphr_pkg::ST_IDLE;
            used_reg      <= '0;
            ovf_reg       <= '0;
            peak_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            ovf_reg       <= ovf_next;
            peak_reg      <= peak_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        total_reg    <= total_next;
        cur_reg      <= cur_next;
        kind_reg     <= kind_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[sv/aphr_checker.sv]
// Port-level checker for the user-agent peak ratio block, bound to the top level.
// Depends on aphr_pkg and agent_hash_peak_ratio.
`timescale 1ns / 1ps

module aphr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input aphr_pkg::out_t out_data
);

    // A result that is not taken must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // The block is busy after each input transaction and does not accept another straight away.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input accepted again too soon");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_total |-> out_data.peak_ratio == 17'd0)
        else $error("nonzero ratio on a zero total");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.peak_ratio <= aphr_pkg::RATIO_ONE &&
                      (out_data.hit_kind == aphr_pkg::KIND_EXISTING ||
                       out_data.hit_kind == aphr_pkg::KIND_NEW ||
                       out_data.hit_kind == aphr_pkg::KIND_OVERFLOW))
        else $error("ratio or hit kind out of range");

    // Any tracked request leaves a peak of at least one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit_kind != aphr_pkg::KIND_OVERFLOW |->
            out_data.peak_requests != 32'd0)
        else $error("zero peak after a tracked request");

endmodule

bind agent_hash_peak_ratio aphr_checker u_aphr_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for agent_hash_peak_ratio: directed and random agent hashes,
// with a scoreboard class that predicts every report and checks it field by field.
// Depends on aphr_pkg and agent_hash_peak_ratio.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_REQUESTS = 1880;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF_AT = 4000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES = 60;

    class agent_peak_tracker;
        localparam int TRACKED_AGENTS = 15;

        logic [31:0]    agent_hashes[TRACKED_AGENTS];
        logic [31:0]    agent_counts[TRACKED_AGENTS];
        int             agents_used;
        logic [31:0]    overflow_total;
        logic [31:0]    peak_total;
        aphr_pkg::out_t pending_reports[$];
        int             mismatches;
        int             requests_seen;
        int             kind_seen[3];
        int             zero_seen;
        int             saturated_seen;

        function new();
            agents_used = 0;
            overflow_total = '0;
            peak_total = '0;
            mismatches = 0;
            requests_seen = 0;
            zero_seen = 0;
            saturated_seen = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function void note_request(aphr_pkg::in_t req);
            aphr_pkg::out_t rpt;
            logic [31:0]    cur;
            logic [63:0]    quotient;
            bit             found;
            cur = '0;
            found = 1'b0;
            rpt = '0;
            for (int i = 0; i < agents_used; i++) begin
                if (!found && agent_hashes[i] == req.agent_hash) begin
                    agent_counts[i] = bump(agent_counts[i]);
                    cur = agent_counts[i];
                    found = 1'b1;
                end
            end
            if (found) begin
                rpt.hit_kind = aphr_pkg::KIND_EXISTING;
            end else if (agents_used >= TRACKED_AGENTS) begin
                overflow_total = bump(overflow_total);
                rpt.hit_kind = aphr_pkg::KIND_OVERFLOW;
            end else begin
                agent_hashes[agents_used] = req.agent_hash;
                agent_counts[agents_used] = 32'd1;
                agents_used++;
                cur = 32'd1;
                rpt.hit_kind = aphr_pkg::KIND_NEW;
            end
            if (cur > peak_total)
                peak_total = cur;
            if (req.total_requests == '0) begin
                rpt.peak_ratio = '0;
            end else begin
                quotient = {16'd0, peak_total, 16'd0} / {32'd0, req.total_requests};
                rpt.peak_ratio = (quotient > {47'd0, aphr_pkg::RATIO_ONE})
                                 ? aphr_pkg::RATIO_ONE : quotient[16:0];
            end
            rpt.peak_requests = peak_total;
            rpt.overflow_requests = overflow_total;
            rpt.zero_total = (req.total_requests == '0);
            pending_reports.push_back(rpt);
            requests_seen++;
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_report(aphr_pkg::out_t got);
            aphr_pkg::out_t want;
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected report, expected none actual %h", $time, got);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("peak_ratio", 32'(want.peak_ratio), 32'(got.peak_ratio));
            compare_field("peak_requests", want.peak_requests, got.peak_requests);
            compare_field("hit_kind", 32'(want.hit_kind), 32'(got.hit_kind));
            compare_field("overflow_requests", want.overflow_requests,
                          got.overflow_requests);
            compare_field("zero_total", 32'(want.zero_total), 32'(got.zero_total));
            if (want.hit_kind <= aphr_pkg::KIND_OVERFLOW)
                kind_seen[want.hit_kind]++;
            if (want.zero_total)
                zero_seen++;
            if (want.peak_ratio == aphr_pkg::RATIO_ONE)
                saturated_seen++;
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    aphr_pkg::in_t  in_data = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    aphr_pkg::out_t out_data;

    agent_peak_tracker tracker = new();
    logic [31:0] known_agents[15];
    int sent_count = 0;
    int idle_cycles = 0;

    agent_hash_peak_ratio dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            tracker.note_request(in_data);
        if (rst_n && out_valid && out_ready)
            tracker.check_report(out_data);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off that backs up the block.
    initial begin
        int cycle;
        int hold;
        int pattern;
        int pattern_left;
        cycle = 0;
        hold = 0;
        pattern = 0;
        pattern_left = 200;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            cycle++;
            if (cycle == HOLD_OFF_AT)
                hold = HOLD_OFF_CYCLES;
            if (pattern_left == 0) begin
                pattern = $urandom_range(0, 3);
                pattern_left = $urandom_range(64, 512);
            end
            pattern_left--;
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end else begin
                case (pattern)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (cycle % 5 == 0);
                    default: out_ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
            @(posedge clk);
        end
    end

    task automatic offer_request(input logic [31:0] hash, input logic [31:0] total);
        in_valid <= 1'b1;
        in_data <= '{agent_hash: hash, total_requests: total};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    initial begin
        int burst_left;
        int pick;
        logic [31:0] hash;
        logic [31:0] total;
        known_agents = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                         32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000,
                         32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                         32'h0000_0002, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero total, saturation, filling the table, then overflow.
        offer_request(known_agents[0], 32'd0);
        offer_request(known_agents[0], 32'd1);
        offer_request(known_agents[1], 32'hFFFF_FFFF);
        offer_request(known_agents[0], 32'd2);
        offer_request(known_agents[0], 32'd3);
        offer_request(known_agents[0], 32'd7);
        for (int i = 2; i < 15; i++)
            offer_request(known_agents[i], (i == 3) ? 32'h8000_0000 : 32'(i * 3 + 10));
        offer_request(32'hDEAD_BEEF, 32'd0);
        offer_request(known_agents[14], 32'd24);
        pause_sender(40);

        burst_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                hash = known_agents[$urandom_range(0, 1)];
            else if (pick < 70)
                hash = known_agents[$urandom_range(0, 14)];
            else
                hash = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                total = 32'd0;
            else if (pick < 20)
                total = $urandom_range(0, sent_count / 4 + 1);
            else if (pick < 30)
                total = 32'hFFFF_FFFF - $urandom_range(0, 3);
            else if (pick < 45)
                total = $urandom;
            else
                total = sent_count + $urandom_range(0, 20);
            offer_request(hash, total);
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                         : $urandom_range(1, 30);
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80));
            end
        end
        in_valid <= 1'b0;

        while (tracker.pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d hits, %0d new agents, %0d overflow.",
                 tracker.requests_seen, tracker.kind_seen[aphr_pkg::KIND_EXISTING],
                 tracker.kind_seen[aphr_pkg::KIND_NEW],
                 tracker.kind_seen[aphr_pkg::KIND_OVERFLOW]);
        $display("Zero totals %0d, ratios at one %0d, field mismatches %0d.",
                 tracker.zero_seen, tracker.saturated_seen, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
